// File: hw/rtl/lsra_pkg.sv
// shared types and constants for the linear scan register allocator
`timescale 1ns / 1ps

package lsra_pkg;

  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned REG_BITS  = 3;
  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned TEMP_BITS = 16;

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [TEMP_BITS-1:0] temp_t;
  typedef logic [REG_BITS-1:0]  reg_idx_t;
  typedef logic [NUM_REGS-1:0]  reg_vec_t;

  // register indexes, r10 to r15
  localparam reg_idx_t REG_R10 = 3'd0;
  localparam reg_idx_t REG_R11 = 3'd1;
  localparam reg_idx_t REG_R12 = 3'd2;
  localparam reg_idx_t REG_R13 = 3'd3;
  localparam reg_idx_t REG_R14 = 3'd4;
  localparam reg_idx_t REG_R15 = 3'd5;

  // preference order, callee-saved first across a call
  localparam reg_idx_t ORDER_CALL [NUM_REGS] =
    '{REG_R12, REG_R13, REG_R14, REG_R15, REG_R10, REG_R11};
  localparam reg_idx_t ORDER_NOCALL [NUM_REGS] =
    '{REG_R10, REG_R11, REG_R12, REG_R13, REG_R14, REG_R15};

  typedef struct packed {
    logic  new_function;
    temp_t temp_id;
    pos_t  start_pos;
    pos_t  end_pos;
    logic  spans_call;
  } item_t;

  typedef struct packed {
    temp_t    temp_id;
    logic     granted;
    reg_idx_t reg_index;
    logic     victim_valid;
    temp_t    victim_temp_id;
  } result_t;

endpackage

// File: hw/rtl/lsra_in_stage.sv
// input register stage holding one interval beat
`timescale 1ns / 1ps

module lsra_in_stage
  import lsra_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/lsra_alloc.sv
// slot file with expiry, preference pick and latest-end eviction
`timescale 1ns / 1ps

module lsra_alloc
  import lsra_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  reg_vec_t busy_q, busy_d;
  pos_t     end_q   [NUM_REGS];
  temp_t    owner_q [NUM_REGS];

  reg_vec_t live;
  reg_vec_t free;
  reg_idx_t ord [NUM_REGS];
  logic     found;
  reg_idx_t pick;
  reg_idx_t m01, m23, m45, m0123, best;
  logic     evict;
  result_t  res;

  // expiry and first free register in preference order
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      live[i] = busy_q[i] && !item_i.new_function && !(end_q[i] < item_i.start_pos);
      ord[i]  = item_i.spans_call ? ORDER_CALL[i] : ORDER_NOCALL[i];
    end
    free  = ~live;
    found = 1'b0;
    pick  = REG_R10;
    for (int k = NUM_REGS - 1; k >= 0; k--) begin
      if (free[ord[k]]) begin
        found = 1'b1;
        pick  = ord[k];
      end
    end
  end

  // latest end, lower index wins ties
  always_comb begin
    m01   = (end_q[REG_R11] > end_q[REG_R10]) ? REG_R11 : REG_R10;
    m23   = (end_q[REG_R13] > end_q[REG_R12]) ? REG_R13 : REG_R12;
    m45   = (end_q[REG_R15] > end_q[REG_R14]) ? REG_R15 : REG_R14;
    m0123 = (end_q[m23] > end_q[m01]) ? m23 : m01;
    best  = (end_q[m45] > end_q[m0123]) ? m45 : m0123;
    evict = !found && (end_q[best] > item_i.end_pos);
  end

  always_comb begin
    res.temp_id        = item_i.temp_id;
    res.granted        = found || evict;
    res.reg_index      = found ? pick : (evict ? best : REG_R10);
    res.victim_valid   = evict;
    res.victim_temp_id = evict ? owner_q[best] : '0;
    busy_d             = live;
    if (res.granted) begin
      busy_d[res.reg_index] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (fire_i) begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res.granted) begin
      end_q[res.reg_index]   <= item_i.end_pos;
      owner_q[res.reg_index] <= item_i.temp_id;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  a_victim_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.victim_valid |-> res.granted && (free == '0))
    else $error("victim reported while a register was free");

  a_free_grants_plainly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (free != '0) |-> res.granted && !res.victim_valid)
    else $error("free register not granted");

  a_new_function_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.new_function |=> $countones(busy_q) == 1)
    else $error("slots not cleared at new function");

  a_busy_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(busy_q))
    else $error("slot state changed without a beat");
`endif

endmodule

// File: hw/rtl/linear_scan_register_allocator_unit.sv
// top level of the linear scan register allocator
`timescale 1ns / 1ps

// usage
//   input channel: in_valid_i / in_ready_o with one live interval a beat,
//   intervals given in order of start position
//   output channel: out_valid_o / out_ready_i with one allocation result a
//   beat for every interval, in input order
//   path: an accepted interval is held in the input register, and its
//   allocation result is registered in the output register
//   throughput: one interval every cycle while the output is not stalled;
//   the six slots are compared in parallel between the input register and
//   the output register, and the slot state is written back with each result
//   reset: rst_ni clears both stages and marks every register free
//   stall: while out_ready_i is low the result holds and one more interval
//   is taken into the input register, after which in_ready_o drops
//   new_function_i frees every register before that interval is handled

module linear_scan_register_allocator_unit
  import lsra_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     new_function_i,
  input  temp_t    temp_id_i,
  input  pos_t     start_pos_i,
  input  pos_t     end_pos_i,
  input  logic     spans_call_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output temp_t    out_temp_id_o,
  output logic     granted_o,
  output reg_idx_t reg_index_o,
  output logic     victim_valid_o,
  output temp_t    victim_temp_id_o
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    take;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  always_comb begin
    in_item.new_function = new_function_i;
    in_item.temp_id      = temp_id_i;
    in_item.start_pos    = start_pos_i;
    in_item.end_pos      = end_pos_i;
    in_item.spans_call   = spans_call_i;
  end

  assign take = stage_valid && (!out_valid_q || out_ready_i);

  lsra_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  lsra_alloc u_alloc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (take),
    .item_i (stage_item),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_temp_id_o    = out_q.temp_id;
  assign granted_o        = out_q.granted;
  assign reg_index_o      = out_q.reg_index;
  assign victim_valid_o   = out_q.victim_valid;
  assign victim_temp_id_o = out_q.victim_temp_id;

endmodule
